@@ src/assert_macros.svh @@
// Assertion macros used by the order queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/eoq_pkg.sv @@
// Constants and types of the elevator order queue.
package eoq_pkg;

    localparam int FLOORS     = 4;
    localparam int KINDS      = 3;
    localparam int SLOTS      = 12;

    localparam int LATCH_BITS = KINDS * FLOORS;
    localparam int FLOOR_W    = $clog2(FLOORS);
    localparam int FLOOR_CW   = (FLOOR_W > 2) ? FLOOR_W : 2;
    localparam int KIND_W     = 2;
    localparam int SLOT_AW    = $clog2(SLOTS);
    localparam int SLOT_CW    = $clog2(SLOTS + 1);
    localparam int BIT_IW     = $clog2(LATCH_BITS);
    localparam int BIT_CW     = $clog2(LATCH_BITS + 1);

    localparam logic [KIND_W-1:0] KIND_CAB = 2'd2;

    localparam logic [2:0] FUNC_CLEAR_ALL   = 3'd0;
    localparam logic [2:0] FUNC_SCAN        = 3'd1;
    localparam logic [2:0] FUNC_POP         = 3'd2;
    localparam logic [2:0] FUNC_CLEAR_FLOOR = 3'd3;
    localparam logic [2:0] FUNC_QUERY       = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FLOOR_W-1:0] floor;
    } order_t;

    typedef struct packed {
        logic floor_eq;
        logic kind_eq;
        logic kind_cab;
    } cmp_t;

endpackage

@@ src/elevator_order_queue.sv @@
// Elevator order queue: circular order memory, button latch and order in service.
// Steps: clear all goes straight to the result; pop reads the head entry; query and clear
// floor read and evaluate each stored order in turn; scan checks each latched bit, then a
// read and a compare per stored order and an append if no duplicate is found.
// Throughput: one request in flight; the next is taken once the result is registered, and
// a held result (m_ready low) stalls the sequencer. Reset (sync, aresetn low): all empty.
`include "assert_macros.svh"

module elevator_order_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [1:0]  s_floor_sel,
    input  logic        s_travel_dir,
    input  logic [11:0] s_pressed_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_floor_hit,
    output logic        m_serving_valid,
    output logic [1:0]  m_serving_button,
    output logic [1:0]  m_serving_floor
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a request
    localparam logic [2:0] ST_BIT  = 3'd1;  // scan: look at one latch bit
    localparam logic [2:0] ST_RD   = 3'd2;  // read queue entry idx, or finish the sweep
    localparam logic [2:0] ST_EV   = 3'd3;  // evaluate the entry just read
    localparam logic [2:0] ST_DONE = 3'd4;  // hand the result to the output register

    logic [2:0]                        state_reg, state_next;
    logic [2:0]                        func_reg, func_next;
    logic [1:0]                        floor_sel_reg, floor_sel_next;
    logic                              dir_reg, dir_next;
    logic                              hit_reg, hit_next;

    // Queue bookkeeping: head position in the ring and number of stored orders.
    logic [eoq_pkg::SLOT_AW-1:0]       head_reg, head_next;
    logic [eoq_pkg::SLOT_CW-1:0]       count_reg, count_next;
    logic [eoq_pkg::SLOT_CW-1:0]       idx_reg, idx_next;     // read position in a sweep
    logic [eoq_pkg::SLOT_CW-1:0]       wr_ptr_reg, wr_ptr_next; // compaction write position

    logic [eoq_pkg::LATCH_BITS-1:0]    latch_reg, latch_next;

    // Scan walk: bit index plus its kind and floor, stepped together.
    logic [eoq_pkg::BIT_CW-1:0]        bit_reg, bit_next;
    logic [eoq_pkg::KIND_W-1:0]        kind_cnt_reg, kind_cnt_next;
    logic [eoq_pkg::FLOOR_W-1:0]       floor_cnt_reg, floor_cnt_next;

    logic                              serving_en_reg, serving_en_next;
    eoq_pkg::order_t                   serving_reg, serving_next;

    logic                              m_valid_reg, m_valid_next;
    logic                              out_hit_reg, out_hit_next;
    logic                              out_sv_reg, out_sv_next;
    logic [1:0]                        out_btn_reg, out_btn_next;
    logic [1:0]                        out_flr_reg, out_flr_next;

    // Order memory, one port: read or write at mem_addr each cycle.
    eoq_pkg::order_t                   mem [eoq_pkg::SLOTS];
    eoq_pkg::order_t                   rd_data_reg;
    logic                              mem_rd_en;
    logic                              mem_wr_en;
    eoq_pkg::order_t                   mem_wr_data;
    logic [eoq_pkg::SLOT_AW-1:0]       mem_addr;

    // Ring address unit and the shared order comparator.
    logic [eoq_pkg::SLOT_CW-1:0]       offset;
    logic [eoq_pkg::SLOT_CW:0]         addr_sum;
    eoq_pkg::order_t                   cmp_src;
    logic [eoq_pkg::FLOOR_CW-1:0]      tgt_floor;
    logic [eoq_pkg::KIND_W-1:0]        tgt_kind;
    eoq_pkg::cmp_t                     cmp;

    logic [eoq_pkg::LATCH_BITS-1:0]    floor_bits;
    logic                              bit_adv;
    logic                              s_floor_ok;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_floor_hit      = out_hit_reg;
    assign m_serving_valid  = out_sv_reg;
    assign m_serving_button = out_btn_reg;
    assign m_serving_floor  = out_flr_reg;

    // Compaction writes use the write pointer, everything else the read index.
    assign offset   = (state_reg == ST_EV) ? wr_ptr_reg : idx_reg;
    assign addr_sum = (eoq_pkg::SLOT_CW + 1)'(head_reg) + (eoq_pkg::SLOT_CW + 1)'(offset);

    always_comb begin
        if (addr_sum >= (eoq_pkg::SLOT_CW + 1)'(eoq_pkg::SLOTS)) begin
            mem_addr = eoq_pkg::SLOT_AW'(addr_sum - (eoq_pkg::SLOT_CW + 1)'(eoq_pkg::SLOTS));
        end else begin
            mem_addr = eoq_pkg::SLOT_AW'(addr_sum);
        end
    end

    // Comparator: against the order in service while scanning a bit, else the read entry.
    assign cmp_src   = (state_reg == ST_BIT) ? serving_reg : rd_data_reg;
    assign tgt_floor = (func_reg == eoq_pkg::FUNC_SCAN) ? eoq_pkg::FLOOR_CW'(floor_cnt_reg)
                                                        : eoq_pkg::FLOOR_CW'(floor_sel_reg);
    assign tgt_kind  = (func_reg == eoq_pkg::FUNC_QUERY) ? {1'b0, dir_reg} : kind_cnt_reg;

    assign cmp.floor_eq = (eoq_pkg::FLOOR_CW'(cmp_src.floor) == tgt_floor);
    assign cmp.kind_eq  = (cmp_src.kind == tgt_kind);
    assign cmp.kind_cab = (cmp_src.kind == eoq_pkg::KIND_CAB);

    // Latch bits of the selected floor, one per kind.
    always_comb begin
        for (int i = 0; i < eoq_pkg::LATCH_BITS; i++) begin
            floor_bits[i] = (eoq_pkg::FLOOR_CW'(i % eoq_pkg::FLOORS) ==
                             eoq_pkg::FLOOR_CW'(floor_sel_reg));
        end
    end

    assign s_floor_ok = (32'(s_floor_sel) < 32'(eoq_pkg::FLOORS));

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        floor_sel_next  = floor_sel_reg;
        dir_next        = dir_reg;
        hit_next        = hit_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        latch_next      = latch_reg;
        bit_next        = bit_reg;
        kind_cnt_next   = kind_cnt_reg;
        floor_cnt_next  = floor_cnt_reg;
        serving_en_next = serving_en_reg;
        serving_next    = serving_reg;
        m_valid_next    = m_valid_reg;
        out_hit_next    = out_hit_reg;
        out_sv_next     = out_sv_reg;
        out_btn_next    = out_btn_reg;
        out_flr_next    = out_flr_reg;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_data     = rd_data_reg;
        bit_adv         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next      = s_func;
                    floor_sel_next = s_floor_sel;
                    dir_next       = s_travel_dir;
                    hit_next       = 1'b0;
                    idx_next       = '0;
                    wr_ptr_next    = '0;
                    bit_next       = '0;
                    kind_cnt_next  = '0;
                    floor_cnt_next = '0;
                    unique case (s_func)
                        eoq_pkg::FUNC_CLEAR_ALL: begin
                            count_next = '0;
                            latch_next = '0;
                            state_next = ST_DONE;
                        end
                        eoq_pkg::FUNC_SCAN: begin
                            latch_next = latch_reg | eoq_pkg::LATCH_BITS'(s_pressed_mask);
                            state_next = ST_BIT;
                        end
                        eoq_pkg::FUNC_POP: begin
                            if (count_reg == '0) begin
                                serving_en_next = 1'b0;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        eoq_pkg::FUNC_CLEAR_FLOOR: begin
                            state_next = s_floor_ok ? ST_RD : ST_DONE;
                        end
                        eoq_pkg::FUNC_QUERY: begin
                            state_next = ST_RD;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_BIT: begin
                if (bit_reg == eoq_pkg::BIT_CW'(eoq_pkg::LATCH_BITS)) begin
                    state_next = ST_DONE;
                end else if (latch_reg[bit_reg[eoq_pkg::BIT_IW-1:0]] &&
                             !(serving_en_reg && cmp.floor_eq && cmp.kind_eq)) begin
                    idx_next   = '0;
                    state_next = ST_RD;
                end else begin
                    bit_adv = 1'b1;
                end
            end

            ST_RD: begin
                if (idx_reg == count_reg) begin
                    // End of the sweep over stored orders.
                    priority case (func_reg)
                        eoq_pkg::FUNC_SCAN: begin
                            // No duplicate: append if there is room, else drop.
                            if (count_reg < eoq_pkg::SLOT_CW'(eoq_pkg::SLOTS)) begin
                                mem_wr_en        = 1'b1;
                                mem_wr_data.kind = kind_cnt_reg;
                                mem_wr_data.floor = floor_cnt_reg;
                                count_next       = count_reg + eoq_pkg::SLOT_CW'(1);
                            end
                            bit_adv = 1'b1;
                        end
                        eoq_pkg::FUNC_CLEAR_FLOOR: begin
                            count_next = wr_ptr_reg;
                            latch_next = latch_reg & ~floor_bits;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end else begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_EV;
                end
            end

            ST_EV: begin
                priority case (func_reg)
                    eoq_pkg::FUNC_POP: begin
                        serving_next    = rd_data_reg;
                        serving_en_next = 1'b1;
                        head_next       = (head_reg == eoq_pkg::SLOT_AW'(eoq_pkg::SLOTS - 1))
                                          ? '0 : head_reg + eoq_pkg::SLOT_AW'(1);
                        count_next      = count_reg - eoq_pkg::SLOT_CW'(1);
                        state_next      = ST_DONE;
                    end
                    eoq_pkg::FUNC_SCAN: begin
                        if (cmp.floor_eq && cmp.kind_eq) begin
                            bit_adv = 1'b1;  // already queued
                        end else begin
                            idx_next   = idx_reg + eoq_pkg::SLOT_CW'(1);
                            state_next = ST_RD;
                        end
                    end
                    eoq_pkg::FUNC_CLEAR_FLOOR: begin
                        // Keep orders of other floors, packed toward the head.
                        if (!cmp.floor_eq) begin
                            mem_wr_en   = 1'b1;
                            wr_ptr_next = wr_ptr_reg + eoq_pkg::SLOT_CW'(1);
                        end
                        idx_next   = idx_reg + eoq_pkg::SLOT_CW'(1);
                        state_next = ST_RD;
                    end
                    eoq_pkg::FUNC_QUERY: begin
                        if (cmp.floor_eq && (cmp.kind_eq || cmp.kind_cab)) begin
                            hit_next = 1'b1;
                        end
                        idx_next   = idx_reg + eoq_pkg::SLOT_CW'(1);
                        state_next = ST_RD;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_hit_next = hit_reg;
                    out_sv_next  = serving_en_reg;
                    out_btn_next = serving_en_reg ? serving_reg.kind : 2'd0;
                    out_flr_next = serving_en_reg ? 2'(serving_reg.floor) : 2'd0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next latch bit, kind-major and floor-minor.
        if (bit_adv) begin
            bit_next   = bit_reg + eoq_pkg::BIT_CW'(1);
            state_next = ST_BIT;
            if (floor_cnt_reg == eoq_pkg::FLOOR_W'(eoq_pkg::FLOORS - 1)) begin
                floor_cnt_next = '0;
                kind_cnt_next  = kind_cnt_reg + eoq_pkg::KIND_W'(1);
            end else begin
                floor_cnt_next = floor_cnt_reg + eoq_pkg::FLOOR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[mem_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            latch_reg      <= '0;
            serving_en_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            latch_reg      <= latch_next;
            serving_en_reg <= serving_en_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        floor_sel_reg <= floor_sel_next;
        dir_reg       <= dir_next;
        hit_reg       <= hit_next;
        idx_reg       <= idx_next;
        wr_ptr_reg    <= wr_ptr_next;
        bit_reg       <= bit_next;
        kind_cnt_reg  <= kind_cnt_next;
        floor_cnt_reg <= floor_cnt_next;
        serving_reg   <= serving_next;
        out_hit_reg   <= out_hit_next;
        out_sv_reg    <= out_sv_next;
        out_btn_reg   <= out_btn_next;
        out_flr_reg   <= out_flr_next;
    end

    `ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= eoq_pkg::SLOT_CW'(eoq_pkg::SLOTS), "order count above queue depth")
    `ASSERT_ALWAYS(a_head_range, aclk, aresetn, head_reg < eoq_pkg::SLOT_AW'(eoq_pkg::SLOTS), "head outside ring")
    `ASSERT_ALWAYS(a_compact_order, aclk, aresetn, !(state_reg == ST_EV && func_reg == eoq_pkg::FUNC_CLEAR_FLOOR) || (wr_ptr_reg <= idx_reg), "compaction write passes read")
    `ASSERT_NEXT(a_done_hold, aclk, aresetn, state_reg == ST_DONE && m_valid_reg && !m_ready, state_reg == ST_DONE, "result overwritten before taken")

endmodule

@@ tb/sv/elevator_order_queue_test.sv @@
// Testbench of the elevator order queue: directed and random requests checked by a predictor.
module elevator_order_queue_test;
    import eoq_pkg::*;

    // Codes the package leaves unnamed.
    localparam logic [KIND_W-1:0] KIND_UP        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DOWN      = 2'd1;
    localparam logic [2:0]        FUNC_NOP_FIRST = 3'd5;
    localparam logic [2:0]        FUNC_NOP_LAST  = 3'd7;
    localparam logic              DIR_UP         = 1'b0;
    localparam logic              DIR_DOWN       = 1'b1;

    localparam int RANDOM_REQUESTS  = 1200;
    localparam int LONG_HOLD_CYCLES = 600;
    // Quiet time after the last expected result, to catch stray results.
    localparam int SETTLE_CYCLES    = 400;
    localparam int REPORT_LIMIT     = 10;
    // Slowest run: ~1300 requests, each a worst-case scan plus gap and stall,
    // and two long hold-offs; the limit is set well above that.
    localparam int RUN_LIMIT        = 8_000_000;

    localparam logic [11:0] NO_BUTTONS  = '0;
    localparam logic [11:0] ALL_BUTTONS = '1;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  floor_sel;
        logic        travel_dir;
        logic [11:0] pressed_mask;
    } request_t;

    typedef struct packed {
        logic       floor_hit;
        logic       serving_valid;
        logic [1:0] serving_button;
        logic [1:0] serving_floor;
    } outcome_t;

    typedef struct packed {
        logic   en;
        order_t ord;
    } slot_t;

    // DUT ports; the inputs are known from time zero.
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func         = FUNC_CLEAR_ALL;
    logic [1:0]  s_floor_sel    = '0;
    logic        s_travel_dir   = 1'b0;
    logic [11:0] s_pressed_mask = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_floor_hit;
    logic        m_serving_valid;
    logic [1:0]  m_serving_button;
    logic [1:0]  m_serving_floor;

    elevator_order_queue i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_floor_sel      (s_floor_sel),
        .s_travel_dir     (s_travel_dir),
        .s_pressed_mask   (s_pressed_mask),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_floor_hit      (m_floor_hit),
        .m_serving_valid  (m_serving_valid),
        .m_serving_button (m_serving_button),
        .m_serving_floor  (m_serving_floor)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: the order queue as a compacted array (enabled
    // entries form a prefix), the button latch and the order in service.
    // ------------------------------------------------------------------
    slot_t                 order_queue [SLOTS];
    logic [LATCH_BITS-1:0] latched_buttons;
    slot_t                 in_service;
    outcome_t              expected_results [$];

    // Sender shaping: burst length left and maximum gap (0 = never idle).
    int burst_left = 0;
    int gap_max    = 0;
    bit offer_held = 1'b0;   // s_valid left high after the last accepted request

    // Long receiver hold-off: the test bumps the ticket, the receiver counts.
    int hold_ticket = 0;
    int hold_taken  = 0;
    int hold_left   = 0;
    logic [7:0] ready_pattern = 8'hFF;
    int         pattern_age   = 0;

    // Statistics and failures.
    int func_seen [8];
    int hits_seen       = 0;
    int results_checked = 0;
    int error_count     = 0;

    function automatic logic [11:0] button_mask(logic [KIND_W-1:0] kind,
                                                logic [FLOOR_W-1:0] fl);
        return 12'b1 << (int'(kind) * FLOORS + int'(fl));
    endfunction

    // Append an order unless it is already queued or in service. A full
    // queue drops it (its latch bit stays set).
    function automatic void queue_order(logic [KIND_W-1:0] kind, logic [FLOOR_W-1:0] fl);
        if (in_service.en && in_service.ord.kind == kind && in_service.ord.floor == fl)
            return;
        for (int i = 0; i < SLOTS; i++) begin
            if (!order_queue[i].en) begin
                order_queue[i].en        = 1'b1;
                order_queue[i].ord.kind  = kind;
                order_queue[i].ord.floor = fl;
                return;
            end
            if (order_queue[i].ord.kind == kind && order_queue[i].ord.floor == fl)
                return;
        end
    endfunction

    // Apply one request to the predictor state and return the result it causes.
    function automatic outcome_t predict_outcome(request_t req);
        outcome_t res;
        int       w;
        res = '0;
        case (req.func)
            FUNC_CLEAR_ALL: begin
                // the order in service survives a clear all
                foreach (order_queue[i]) order_queue[i] = '0;
                latched_buttons = '0;
            end
            FUNC_SCAN: begin
                latched_buttons |= req.pressed_mask[LATCH_BITS-1:0];
                // kind-major, floor-minor walk of the latch
                for (int k = 0; k < KINDS; k++)
                    for (int f = 0; f < FLOORS; f++)
                        if (latched_buttons[k*FLOORS + f])
                            queue_order(KIND_W'(k), FLOOR_W'(f));
            end
            FUNC_POP: begin
                in_service = order_queue[0];
                if (!in_service.en)
                    in_service.ord = '0;
                for (int i = 0; i < SLOTS - 1; i++)
                    order_queue[i] = order_queue[i+1];
                order_queue[SLOTS-1] = '0;
            end
            FUNC_CLEAR_FLOOR: begin
                if (int'(req.floor_sel) < FLOORS) begin
                    // stable compaction, adjacent matches all go
                    w = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (order_queue[i].en && order_queue[i].ord.floor != req.floor_sel) begin
                            order_queue[w] = order_queue[i];
                            w++;
                        end
                    for (int i = w; i < SLOTS; i++)
                        order_queue[i] = '0;
                    for (int k = 0; k < KINDS; k++)
                        latched_buttons[k*FLOORS + int'(req.floor_sel)] = 1'b0;
                end
            end
            FUNC_QUERY: begin
                foreach (order_queue[i])
                    if (order_queue[i].en && order_queue[i].ord.floor == req.floor_sel &&
                        (order_queue[i].ord.kind == KIND_W'(req.travel_dir) ||
                         order_queue[i].ord.kind == KIND_CAB))
                        res.floor_hit = 1'b1;
            end
            default: ;
        endcase
        res.serving_valid = in_service.en;
        if (in_service.en) begin
            res.serving_button = in_service.ord.kind;
            res.serving_floor  = in_service.ord.floor;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Offers one request, waits for its handshake, predicts
    // the result, then either keeps valid high for the next request of the
    // burst or drops it for a random, nonzero gap (so valid is never
    // lowered and raised in the same step).
    // ------------------------------------------------------------------
    task automatic send_request(input logic [2:0] func, input logic [1:0] fl,
                                input logic dir, input logic [11:0] mask);
        request_t req;
        outcome_t want;
        req = '{func: func, floor_sel: fl, travel_dir: dir, pressed_mask: mask};
        s_valid        <= 1'b1;
        s_func         <= req.func;
        s_floor_sel    <= req.floor_sel;
        s_travel_dir   <= req.travel_dir;
        s_pressed_mask <= req.pressed_mask;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_outcome(req);
        expected_results.push_back(want);
        func_seen[req.func]++;
        if (want.floor_hit)
            hits_seen++;
        if (gap_max == 0 || burst_left > 0) begin
            if (burst_left > 0)
                burst_left--;
            offer_held = 1'b1;
        end else begin
            s_valid    <= 1'b0;
            offer_held = 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Sender pause: drop valid and wait until every result has come back.
    task automatic wait_all_results();
        if (offer_held) begin
            s_valid    <= 1'b0;
            offer_held = 1'b0;
        end
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side. m_ready follows a rotating 8-bit pattern that is
    // redrawn now and then (all ones gives stall-free stretches); a bumped
    // hold ticket forces a long hold-off so the block backs up.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_ticket != hold_taken) begin
                hold_taken = hold_ticket;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (pattern_age == 0) begin
                case ($urandom_range(0, 2))
                    0:       ready_pattern = 8'hFF;
                    1:       ready_pattern = 8'($urandom);
                    default: ready_pattern = 8'($urandom) | 8'($urandom);
                endcase
                pattern_age = $urandom_range(16, 96);
            end
            pattern_age--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready       <= ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
        end
    end

    // Each accepted result is compared with the oldest prediction.
    always @(posedge aclk) begin : check_results
        outcome_t want;
        outcome_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{floor_hit: m_floor_hit, serving_valid: m_serving_valid,
                    serving_button: m_serving_button, serving_floor: m_serving_floor};
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("[%0t] result with no request pending: hit %b valid %b btn %0d fl %0d",
                             $realtime, got.floor_hit, got.serving_valid,
                             got.serving_button, got.serving_floor);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got !== want) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("[%0t] result %0d expected: hit %b valid %b btn %0d fl %0d",
                                 $realtime, results_checked, want.floor_hit,
                                 want.serving_valid, want.serving_button, want.serving_floor);
                        $display("[%0t] result %0d actual:   hit %b valid %b btn %0d fl %0d",
                                 $realtime, results_checked, got.floor_hit,
                                 got.serving_valid, got.serving_button, got.serving_floor);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Query and pop with nothing queued: no hit, service becomes idle.
    task automatic test_empty_queue();
        send_request(FUNC_QUERY, 2'd0, DIR_UP, NO_BUTTONS);
        send_request(FUNC_POP, 2'd3, DIR_DOWN, NO_BUTTONS);
        send_request(FUNC_QUERY, 2'd3, DIR_DOWN, ALL_BUTTONS);
        wait_all_results();
    endtask

    // Every button at once fills the queue; repeat scans add no duplicates
    // and never re-add the order in service.
    task automatic test_fill_and_duplicates();
        send_request(FUNC_SCAN, 2'd0, DIR_UP, ALL_BUTTONS);
        send_request(FUNC_SCAN, 2'd1, DIR_UP, ALL_BUTTONS);
        send_request(FUNC_QUERY, 2'd3, DIR_DOWN, NO_BUTTONS);
        send_request(FUNC_POP, 2'd0, DIR_UP, NO_BUTTONS);
        send_request(FUNC_SCAN, 2'd0, DIR_UP, NO_BUTTONS);
        send_request(FUNC_POP, 2'd0, DIR_UP, NO_BUTTONS);
        wait_all_results();
    endtask

    // Clear floor with adjacent matches, a floor with no orders, and the
    // floor of the order in service (which must stay).
    task automatic test_clear_floor();
        send_request(FUNC_CLEAR_ALL, 2'd0, DIR_UP, NO_BUTTONS);
        send_request(FUNC_SCAN, 2'd0, DIR_UP,
                     button_mask(KIND_UP, 2'd0) | button_mask(KIND_UP, 2'd1) |
                     button_mask(KIND_DOWN, 2'd1));
        send_request(FUNC_CLEAR_FLOOR, 2'd1, DIR_UP, NO_BUTTONS);
        send_request(FUNC_QUERY, 2'd1, DIR_UP, NO_BUTTONS);
        send_request(FUNC_CLEAR_FLOOR, 2'd3, DIR_DOWN, NO_BUTTONS);
        send_request(FUNC_POP, 2'd0, DIR_UP, NO_BUTTONS);
        send_request(FUNC_CLEAR_FLOOR, 2'd0, DIR_UP, NO_BUTTONS);
        wait_all_results();
    endtask

    // Clear all empties queue and latch but keeps the order in service.
    task automatic test_clear_all();
        send_request(FUNC_SCAN, 2'd2, DIR_DOWN, button_mask(KIND_CAB, 2'd2));
        send_request(FUNC_POP, 2'd0, DIR_UP, NO_BUTTONS);
        send_request(FUNC_CLEAR_ALL, 2'd0, DIR_UP, ALL_BUTTONS);
        send_request(FUNC_POP, 2'd0, DIR_UP, NO_BUTTONS);
        wait_all_results();
    endtask

    // Direction match versus cab orders.
    task automatic test_query_directions();
        send_request(FUNC_SCAN, 2'd0, DIR_UP,
                     button_mask(KIND_UP, 2'd2) | button_mask(KIND_DOWN, 2'd3) |
                     button_mask(KIND_CAB, 2'd1));
        send_request(FUNC_QUERY, 2'd2, DIR_UP, NO_BUTTONS);
        send_request(FUNC_QUERY, 2'd2, DIR_DOWN, NO_BUTTONS);
        send_request(FUNC_QUERY, 2'd1, DIR_DOWN, NO_BUTTONS);
        send_request(FUNC_QUERY, 2'd3, DIR_UP, NO_BUTTONS);
        wait_all_results();
    endtask

    // Unused codes change nothing and report no hit.
    task automatic test_unused_codes();
        send_request(FUNC_NOP_FIRST, 2'd3, DIR_DOWN, ALL_BUTTONS);
        send_request(FUNC_NOP_LAST, 2'd1, DIR_UP, ALL_BUTTONS);
        wait_all_results();
    endtask

    // Random request with the function mix and mask shapes used below.
    task automatic send_random_request();
        logic [2:0]  func;
        logic [11:0] mask;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            func = FUNC_CLEAR_ALL;
        else if (roll < 38)
            func = FUNC_SCAN;
        else if (roll < 62)
            func = FUNC_POP;
        else if (roll < 74)
            func = FUNC_CLEAR_FLOOR;
        else if (roll < 95)
            func = FUNC_QUERY;
        else
            func = 3'($urandom_range(FUNC_NOP_FIRST, FUNC_NOP_LAST));
        // mostly a few buttons per scan, like real traffic
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            mask = NO_BUTTONS;
            repeat ($urandom_range(1, 3)) mask[$urandom_range(0, 11)] = 1'b1;
        end else if (roll < 8) begin
            mask = 12'($urandom);
        end else if (roll < 9) begin
            mask = NO_BUTTONS;
        end else begin
            mask = ALL_BUTTONS;
        end
        send_request(func, 2'($urandom), 1'($urandom), mask);
    endtask

    // Receiver holds off for a long stretch while the sender keeps
    // offering back to back; the block fills and stalls its input.
    task automatic test_backpressure();
        gap_max     = 0;
        hold_ticket <= hold_ticket + 1;
        repeat (10) send_random_request();
        wait_all_results();
    endtask

    // Bulk random traffic with changing sender gaps, a second hold-off and
    // occasional full drains.
    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 4;
                    default: gap_max = 24;
                endcase
            end
            if (n == RANDOM_REQUESTS / 2)
                hold_ticket <= hold_ticket + 1;
            send_random_request();
            if (n % 300 == 299)
                wait_all_results();
        end
        wait_all_results();
    endtask

    initial begin
        int nop_total;
        foreach (order_queue[i]) order_queue[i] = '0;
        latched_buttons = '0;
        in_service      = '0;
        foreach (func_seen[i]) func_seen[i] = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_fill_and_duplicates();
        test_clear_floor();
        test_clear_all();
        test_query_directions();
        test_unused_codes();
        test_backpressure();
        test_random_traffic();

        wait_all_results();
        // Catch any stray result after the last one.
        repeat (SETTLE_CYCLES) @(posedge aclk);

        nop_total = 0;
        for (int c = FUNC_NOP_FIRST; c <= FUNC_NOP_LAST; c++)
            nop_total += func_seen[c];
        $display("Covered %0d clear-all, %0d scan, %0d pop, %0d clear-floor, %0d query (%0d hits),",
                 func_seen[FUNC_CLEAR_ALL], func_seen[FUNC_SCAN], func_seen[FUNC_POP],
                 func_seen[FUNC_CLEAR_FLOOR], func_seen[FUNC_QUERY], hits_seen);
        $display("  %0d unused codes; %0d results checked under gaps, stalls and hold-offs",
                 nop_total, results_checked);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results never arrived", error_count,
                     expected_results.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/eoq_pkg.sv
src/elevator_order_queue.sv
tb/sv/elevator_order_queue_test.sv
